[hw/rtl/mpv_pkg.sv]
// ----------------------------------------------------------------------------
// mpv_pkg: shared types and constants of the Merkle proof verifier
// SHA-256 round constants, initial hash value, fixed root and sequencer states.
// ----------------------------------------------------------------------------
package mpv_pkg;

	// request kinds carried on tuser
	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_LEAF  = 2'd1;
	localparam logic [1:0] REQ_LEVEL = 2'd2;
	localparam logic [1:0] REQ_QUERY = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_META    = 2'd1;
	localparam logic [1:0] ST_REFUSED = 2'd2;

	localparam int unsigned PROOF_LEVELS = 4;
	localparam logic [2:0] LEVEL_DONE = 3'(PROOF_LEVELS + 1);
	localparam logic [2:0] LEVEL_MAX  = 3'(PROOF_LEVELS);
	localparam logic [8:0] MAX_LEAF_BYTES = 9'd255;
	localparam logic [8:0] MAX_LIST_BYTES = 9'd255;
	localparam logic [8:0] COUNT_CAP = 9'd511;

	localparam logic [255:0] ROOT_HASH =
		256'h5ac8202402_37d97d1d390bbca8b70bf339d8d3e892bcdbb14f96000d55ff65be;

	localparam logic [255:0] SHA_IV =
		256'h6a09e667_bb67ae85_3c6ef372_a54ff53a_510e527f_9b05688c_1f83d9ab_5be0cd19;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIN,
		S_LOAD,
		S_COMP,
		S_ADD,
		S_TAKE
	} state_t;

	function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	// SHA-256 round constant
	function automatic logic [31:0] sha_k(logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
			6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
			6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
			6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		sha_k = k;
	endfunction

endpackage

[hw/rtl/merkle_proof_verifier.sv]
// ----------------------------------------------------------------------------
// merkle_proof_verifier: SHA-256 Merkle proof checker over a byte stream
// Hashes a leaf and up to four levels of hash lists, checking each list holds
// the running hash, and reports whether the final hash equals a fixed root.
// ----------------------------------------------------------------------------
// One transaction is a request: clear, query, or one byte of a leaf or level
// message (tlast on the final byte). Every 64th message byte runs one SHA-256
// compression (load, 64 rounds on the single shared round unit, digest add).
// The final byte of a message adds a check state and, when the message is
// hashed, one or two more compressions plus a state that takes the digest.
// The input is not ready while a compression runs. A result is sent for
// clear, query and each final message byte, and sits in an output
// register; no new request is taken while it waits there.
module merkle_proof_verifier (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic [1:0] s_axis_tuser,   // [1:0] req_type
	input  logic       s_axis_tlast,   // last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // [1:0] status, [4:2] level, [5] verified
);

	mpv_pkg::state_t state_q, state_d;

	logic [31:0]  blk_q [16];   // message block, also the schedule shift line
	logic [31:0]  dig_q [8];
	logic [31:0]  wk_q  [8];    // a..h
	logic [5:0]   rnd_q;
	logic [255:0] cur_q;
	logic [2:0]   lvl_q;
	logic [8:0]   cnt_q;
	logic [8:0]   len_q;
	logic         cm_q, hf_q;
	logic [1:0]   kind_q, rt_q;
	logic         fin_q, pass2_q, final_q;
	logic         ov_q;
	logic [7:0]   od_q;

	logic         acc;
	logic         beg;
	logic [8:0]   eff;
	logic         cmv, hfv, mm, wr_ok;
	logic [7:0]   hb;
	logic [31:0]  wr_word;
	logic         verif_now;
	logic         fin_bad;
	logic [1:0]   fin_status;
	logic [31:0]  pad [16];
	logic [31:0]  t1, t2, wnew;
	logic [255:0] dig_flat;

	assign acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == mpv_pkg::S_IDLE) && (!ov_q || m_axis_tready);
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = od_q;

	// message byte bookkeeping
	always_comb begin
		beg = (kind_q != s_axis_tuser) || (cnt_q == 9'd0);
		eff = beg ? 9'd0 : cnt_q;
		cmv = beg ? 1'b1 : cm_q;
		hfv = beg ? 1'b0 : hf_q;
		wr_ok = eff < mpv_pkg::COUNT_CAP;
		hb = cur_q[8'd255 - {eff[4:0], 3'b000} -: 8];
		mm = cmv && (s_axis_tdata == hb);
		wr_word = blk_q[eff[5:2]];
		case (eff[1:0])
			2'd0: wr_word[31:24] = s_axis_tdata;
			2'd1: wr_word[23:16] = s_axis_tdata;
			2'd2: wr_word[15:8] = s_axis_tdata;
			default: wr_word[7:0] = s_axis_tdata;
		endcase
		verif_now = (lvl_q == mpv_pkg::LEVEL_DONE) && (cur_q == mpv_pkg::ROOT_HASH);
	end

	// end-of-message checks and padding
	always_comb begin
		fin_bad = 1'b0;
		fin_status = mpv_pkg::ST_OK;
		if (rt_q == mpv_pkg::REQ_LEAF) begin
			if (cnt_q > mpv_pkg::MAX_LEAF_BYTES) begin
				fin_bad = 1'b1;
				fin_status = mpv_pkg::ST_META;
			end else if (lvl_q != 3'd0) begin
				fin_bad = 1'b1;
				fin_status = mpv_pkg::ST_REFUSED;
			end
		end else if (lvl_q < 3'd1 || lvl_q > mpv_pkg::LEVEL_MAX ||
				cnt_q > mpv_pkg::MAX_LIST_BYTES || cnt_q[4:0] != 5'd0 || !hf_q) begin
			fin_bad = 1'b1;
			fin_status = mpv_pkg::ST_META;
		end
		for (int i = 0; i < 16; i++) begin
			for (int j = 0; j < 4; j++) begin
				if (6'(4 * i + j) < cnt_q[5:0])
					pad[i][31 - 8 * j -: 8] = blk_q[i][31 - 8 * j -: 8];
				else if (6'(4 * i + j) == cnt_q[5:0])
					pad[i][31 - 8 * j -: 8] = 8'h80;
				else
					pad[i][31 - 8 * j -: 8] = 8'h00;
			end
		end
		if (cnt_q[5:0] < 6'd56) begin
			pad[14] = 32'd0;
			pad[15] = {20'd0, cnt_q, 3'b000};
		end
	end

	// shared SHA-256 round and schedule unit
	always_comb begin
		t1 = wk_q[7] + (mpv_pkg::rotr(wk_q[4], 6) ^ mpv_pkg::rotr(wk_q[4], 11) ^
			mpv_pkg::rotr(wk_q[4], 25)) + ((wk_q[4] & wk_q[5]) ^ (~wk_q[4] & wk_q[6])) +
			mpv_pkg::sha_k(rnd_q) + blk_q[0];
		t2 = (mpv_pkg::rotr(wk_q[0], 2) ^ mpv_pkg::rotr(wk_q[0], 13) ^
			mpv_pkg::rotr(wk_q[0], 22)) +
			((wk_q[0] & wk_q[1]) ^ (wk_q[0] & wk_q[2]) ^ (wk_q[1] & wk_q[2]));
		wnew = (mpv_pkg::rotr(blk_q[14], 17) ^ mpv_pkg::rotr(blk_q[14], 19) ^
			(blk_q[14] >> 10)) + blk_q[9] +
			(mpv_pkg::rotr(blk_q[1], 7) ^ mpv_pkg::rotr(blk_q[1], 18) ^ (blk_q[1] >> 3)) +
			blk_q[0];
		dig_flat = {dig_q[0], dig_q[1], dig_q[2], dig_q[3],
			dig_q[4], dig_q[5], dig_q[6], dig_q[7]};
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mpv_pkg::S_IDLE: begin
				if (acc && (s_axis_tuser == mpv_pkg::REQ_LEAF ||
						s_axis_tuser == mpv_pkg::REQ_LEVEL)) begin
					if (wr_ok && eff[5:0] == 6'd63)
						state_d = mpv_pkg::S_LOAD;
					else if (s_axis_tlast)
						state_d = mpv_pkg::S_FIN;
				end
			end
			mpv_pkg::S_FIN: state_d = fin_bad ? mpv_pkg::S_IDLE : mpv_pkg::S_LOAD;
			mpv_pkg::S_LOAD: state_d = mpv_pkg::S_COMP;
			mpv_pkg::S_COMP: if (rnd_q == 6'd63) state_d = mpv_pkg::S_ADD;
			mpv_pkg::S_ADD: begin
				if (pass2_q)
					state_d = mpv_pkg::S_LOAD;
				else if (final_q)
					state_d = mpv_pkg::S_TAKE;
				else if (fin_q)
					state_d = mpv_pkg::S_FIN;
				else
					state_d = mpv_pkg::S_IDLE;
			end
			mpv_pkg::S_TAKE: state_d = mpv_pkg::S_IDLE;
			default: state_d = mpv_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mpv_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			lvl_q <= '0;
			cnt_q <= '0;
			cm_q <= 1'b1;
			hf_q <= 1'b0;
			kind_q <= mpv_pkg::REQ_CLEAR;
			rt_q <= mpv_pkg::REQ_CLEAR;
			fin_q <= 1'b0;
			pass2_q <= 1'b0;
			final_q <= 1'b0;
			rnd_q <= '0;
			ov_q <= 1'b0;
			od_q <= '0;
		end else begin
			// result drained; a request taken this cycle sets ov_q itself
			if (ov_q && m_axis_tready && !acc)
				ov_q <= 1'b0;
			case (state_q)
				mpv_pkg::S_IDLE: begin
					if (acc) begin
						case (s_axis_tuser)
							mpv_pkg::REQ_CLEAR: begin
								cur_q <= '0;
								lvl_q <= '0;
								cnt_q <= '0;
								cm_q <= 1'b1;
								hf_q <= 1'b0;
								kind_q <= mpv_pkg::REQ_CLEAR;
								ov_q <= 1'b1;
								od_q <= {2'b00, 1'b0, 3'd0, mpv_pkg::ST_OK};
							end
							mpv_pkg::REQ_QUERY: begin
								ov_q <= 1'b1;
								od_q <= {2'b00, verif_now, lvl_q,
									verif_now ? mpv_pkg::ST_OK : mpv_pkg::ST_META};
							end
							default: begin
								ov_q <= 1'b0;
								kind_q <= s_axis_tuser;
								rt_q <= s_axis_tuser;
								cm_q <= cmv;
								hf_q <= hfv;
								if (wr_ok) begin
									cnt_q <= eff + 9'd1;
									if (s_axis_tuser == mpv_pkg::REQ_LEVEL && !eff[8]) begin
										if (eff[4:0] == 5'd31) begin
											hf_q <= hfv | mm;
											cm_q <= 1'b1;
										end else begin
											cm_q <= mm;
										end
									end
								end else begin
									cnt_q <= eff;
								end
								fin_q <= s_axis_tlast;
								final_q <= 1'b0;
							end
						endcase
					end
				end
				mpv_pkg::S_FIN: begin
					kind_q <= mpv_pkg::REQ_CLEAR;
					cnt_q <= '0;
					cm_q <= 1'b1;
					hf_q <= 1'b0;
					fin_q <= 1'b0;
					if (fin_bad) begin
						ov_q <= 1'b1;
						od_q <= {2'b00, verif_now, lvl_q, fin_status};
					end else begin
						pass2_q <= cnt_q[5:0] >= 6'd56;
						final_q <= 1'b1;
					end
				end
				mpv_pkg::S_LOAD: rnd_q <= '0;
				mpv_pkg::S_COMP: rnd_q <= rnd_q + 6'd1;
				mpv_pkg::S_ADD: if (pass2_q) pass2_q <= 1'b0;
				mpv_pkg::S_TAKE: begin
					final_q <= 1'b0;
					cur_q <= dig_flat;
					lvl_q <= (rt_q == mpv_pkg::REQ_LEAF) ? 3'd1 : lvl_q + 3'd1;
					ov_q <= 1'b1;
					od_q <= {2'b00,
						((rt_q == mpv_pkg::REQ_LEAF ? 3'd1 : lvl_q + 3'd1) ==
							mpv_pkg::LEVEL_DONE) && (dig_flat == mpv_pkg::ROOT_HASH),
						(rt_q == mpv_pkg::REQ_LEAF) ? 3'd1 : lvl_q + 3'd1, mpv_pkg::ST_OK};
				end
				default: ;
			endcase
		end
	end

	// hash datapath: block, digest and working registers
	always_ff @(posedge clk) begin
		case (state_q)
			mpv_pkg::S_IDLE: begin
				if (acc && (s_axis_tuser == mpv_pkg::REQ_LEAF ||
						s_axis_tuser == mpv_pkg::REQ_LEVEL)) begin
					if (beg)
						for (int i = 0; i < 8; i++)
							dig_q[i] <= mpv_pkg::SHA_IV[255 - 32 * i -: 32];
					if (wr_ok)
						blk_q[eff[5:2]] <= wr_word;
				end
			end
			mpv_pkg::S_FIN: begin
				len_q <= cnt_q;
				if (!fin_bad)
					for (int i = 0; i < 16; i++)
						blk_q[i] <= pad[i];
			end
			mpv_pkg::S_LOAD: begin
				for (int i = 0; i < 8; i++)
					wk_q[i] <= dig_q[i];
			end
			mpv_pkg::S_COMP: begin
				wk_q[7] <= wk_q[6];
				wk_q[6] <= wk_q[5];
				wk_q[5] <= wk_q[4];
				wk_q[4] <= wk_q[3] + t1;
				wk_q[3] <= wk_q[2];
				wk_q[2] <= wk_q[1];
				wk_q[1] <= wk_q[0];
				wk_q[0] <= t1 + t2;
				for (int i = 0; i < 15; i++)
					blk_q[i] <= blk_q[i + 1];
				blk_q[15] <= wnew;
			end
			mpv_pkg::S_ADD: begin
				for (int i = 0; i < 8; i++)
					dig_q[i] <= dig_q[i] + wk_q[i];
				if (pass2_q) begin
					for (int i = 0; i < 15; i++)
						blk_q[i] <= 32'd0;
					blk_q[15] <= {20'd0, len_q, 3'b000};
				end
			end
			default: ;
		endcase
	end

endmodule

[dv/tb_merkle_proof_verifier.sv]
// ----------------------------------------------------------------------------
// tb_merkle_proof_verifier: self-checking testbench of the Merkle proof verifier
// Drives request transactions (clear, query, leaf and level message bytes)
// and checks each result against a typed table row or a SHA-256 predictor.
// ----------------------------------------------------------------------------
module tb_merkle_proof_verifier;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int MIN_ITEMS    = 620;
	localparam int QUIET_AFTER  = 560;
	localparam int DRAIN_CYCLES = 300;

	localparam logic [255:0] MERKLE_ROOT =
		256'h5ac82024_0237d97d_1d390bbc_a8b70bf3_39d8d3e8_92bcdbb1_4f96000d_55ff65be;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] level;
		logic       verified;
	} verdict_t;

	typedef struct packed {
		logic [1:0] req;
		logic [7:0] data;
		logic       lst;
		logic       typed;
		verdict_t   want;
	} req_row_t;

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;

	merkle_proof_verifier dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// predictor state
	logic [255:0] run_hash;
	int           run_level;
	logic [31:0]  dig [8];
	logic [31:0]  blk [16];
	int           msg_count;
	logic         chunk_ok;
	logic         hash_seen;
	logic [1:0]   open_req;
	logic         msg_open;

	verdict_t verdict_q [$];
	int       n_items, n_results, n_errors, n_proofs;
	logic     req_taken, quiet, drv_typed;
	verdict_t drv_want;

	// directed requests; typed rows carry a result fixed by inspection
	req_row_t dir_rows [10] = '{
		'{mpv_pkg::REQ_CLEAR, 8'h00, 1'b1, 1'b1, '{mpv_pkg::ST_OK, 3'd0, 1'b0}},
		'{mpv_pkg::REQ_QUERY, 8'hff, 1'b0, 1'b1, '{mpv_pkg::ST_META, 3'd0, 1'b0}},
		'{mpv_pkg::REQ_LEVEL, 8'h00, 1'b1, 1'b1, '{mpv_pkg::ST_META, 3'd0, 1'b0}},
		'{mpv_pkg::REQ_LEAF,  8'h00, 1'b0, 1'b0, '{mpv_pkg::ST_OK, 3'd0, 1'b0}},
		'{mpv_pkg::REQ_LEVEL, 8'hff, 1'b0, 1'b0, '{mpv_pkg::ST_OK, 3'd0, 1'b0}},
		'{mpv_pkg::REQ_LEAF,  8'hff, 1'b1, 1'b0, '{mpv_pkg::ST_OK, 3'd0, 1'b0}},
		'{mpv_pkg::REQ_LEAF,  8'h5a, 1'b1, 1'b1, '{mpv_pkg::ST_REFUSED, 3'd1, 1'b0}},
		'{mpv_pkg::REQ_QUERY, 8'h00, 1'b1, 1'b1, '{mpv_pkg::ST_META, 3'd1, 1'b0}},
		'{mpv_pkg::REQ_LEVEL, 8'h12, 1'b1, 1'b1, '{mpv_pkg::ST_META, 3'd1, 1'b0}},
		'{mpv_pkg::REQ_CLEAR, 8'hff, 1'b0, 1'b1, '{mpv_pkg::ST_OK, 3'd0, 1'b0}}};

	function automatic logic [31:0] ror32(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [7:0] hash_byte(int i);
		return run_hash[255 - 8 * i -: 8];
	endfunction

	function automatic logic proof_done();
		return run_level == mpv_pkg::PROOF_LEVELS + 1 && run_hash == MERKLE_ROOT;
	endfunction

	task automatic sha_block();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int i = 0; i < 16; i++) w[i] = blk[i];
		for (int i = 16; i < 64; i++) begin
			w[i] = w[i-16] + w[i-7]
				+ (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
				+ (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
		end
		{a, b, c, d, e, f, g, h} = {dig[0], dig[1], dig[2], dig[3],
			dig[4], dig[5], dig[6], dig[7]};
		for (int i = 0; i < 64; i++) begin
			t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_K[i] + w[i];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		dig[0] += a; dig[1] += b; dig[2] += c; dig[3] += d;
		dig[4] += e; dig[5] += f; dig[6] += g; dig[7] += h;
	endtask

	task automatic put_blk(int pos, logic [7:0] v);
		blk[(pos >> 2) & 15][(3 - (pos & 3)) * 8 +: 8] = v;
	endtask

	// padding, length word and final compression(s), digest into run_hash
	task automatic close_hash(int len);
		int pos;
		pos = len & 63;
		put_blk(pos, 8'h80);
		pos++;
		if (pos > 56) begin
			while (pos < 64) begin
				put_blk(pos, 8'h00);
				pos++;
			end
			sha_block();
			pos = 0;
		end
		while (pos < 56) begin
			put_blk(pos, 8'h00);
			pos++;
		end
		blk[14] = '0;
		blk[15] = 32'(len * 8);
		sha_block();
		run_hash = {dig[0], dig[1], dig[2], dig[3], dig[4], dig[5], dig[6], dig[7]};
	endtask

	task automatic clear_verifier();
		run_hash = '0;
		run_level = 0;
		foreach (dig[i]) dig[i] = '0;
		foreach (blk[i]) blk[i] = '0;
		msg_count = 0;
		chunk_ok = 1'b1;
		hash_seen = 1'b0;
		msg_open = 1'b0;
		open_req = mpv_pkg::REQ_CLEAR;
	endtask

	// one request transaction through the verifier; got=0 when no result follows
	task automatic step_verifier(input logic [1:0] req, input logic [7:0] data,
			input logic lst, output logic got, output verdict_t v);
		int len, ci;
		got = 1'b1;
		v.status = mpv_pkg::ST_OK;
		if (req == mpv_pkg::REQ_CLEAR) begin
			clear_verifier();
		end else if (req == mpv_pkg::REQ_QUERY) begin
			v.status = proof_done() ? mpv_pkg::ST_OK : mpv_pkg::ST_META;
		end else begin
			if (!msg_open || open_req != req || msg_count == 0) begin
				foreach (dig[i]) dig[i] = mpv_pkg::SHA_IV[255 - 32 * i -: 32];
				msg_count = 0;
				chunk_ok = 1'b1;
				hash_seen = 1'b0;
				open_req = req;
				msg_open = 1'b1;
			end
			if (msg_count < 511) begin
				put_blk(msg_count & 63, data);
				if ((msg_count & 63) == 63) sha_block();
				if (req == mpv_pkg::REQ_LEVEL && msg_count < 256) begin
					ci = msg_count & 31;
					if (data != hash_byte(ci)) chunk_ok = 1'b0;
					if (ci == 31) begin
						if (chunk_ok) hash_seen = 1'b1;
						chunk_ok = 1'b1;
					end
				end
				msg_count++;
			end
			if (!lst) begin
				got = 1'b0;
				return;
			end
			len = msg_count;
			msg_open = 1'b0;
			msg_count = 0;
			if (req == mpv_pkg::REQ_LEAF) begin
				if (len > 255) v.status = mpv_pkg::ST_META;
				else if (run_level != 0) v.status = mpv_pkg::ST_REFUSED;
				else begin
					close_hash(len);
					run_level = 1;
				end
			end else if (run_level < 1 || run_level > mpv_pkg::PROOF_LEVELS || len > 255
					|| len % 32 != 0 || !hash_seen) begin
				v.status = mpv_pkg::ST_META;
			end else begin
				close_hash(len);
				run_level++;
				if (run_level == mpv_pkg::PROOF_LEVELS + 1) n_proofs++;
			end
			chunk_ok = 1'b1;
			hash_seen = 1'b0;
		end
		v.level = 3'(run_level);
		v.verified = proof_done();
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// accepted requests feed the predictor; accepted results are checked
	always @(posedge clk) begin
		logic     got;
		verdict_t v, seen;
		req_taken <= s_axis_tvalid && s_axis_tready;
		if (m_axis_tvalid && m_axis_tready) begin
			seen.status = m_axis_tdata[1:0];
			seen.level = m_axis_tdata[4:2];
			seen.verified = m_axis_tdata[5];
			n_results++;
			if (verdict_q.size() == 0) begin
				n_errors++;
				if (n_errors <= 10) $display("unexpected result %h", m_axis_tdata);
			end else begin
				v = verdict_q.pop_front();
				if (seen !== v || m_axis_tdata[7:6] !== 2'b00) begin
					n_errors++;
					if (n_errors <= 10)
						$display("result %0d: exp status %0d level %0d verified %0d, got %h",
							n_results, v.status, v.level, v.verified, m_axis_tdata);
				end
			end
		end
		if (s_axis_tvalid && s_axis_tready) begin
			step_verifier(s_axis_tuser, s_axis_tdata, s_axis_tlast, got, v);
			if (got) verdict_q.push_back(drv_typed ? drv_want : v);
		end
	end

	// result side stalls in bursts
	initial begin
		int hold;
		m_axis_tready = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				m_axis_tready = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(0, 12);
				m_axis_tready = 1'b0;
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	// watchdog
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("FAIL");
		$finish;
	end

	task automatic send_req(logic [1:0] req, logic [7:0] data, logic lst);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = req;
		s_axis_tdata = data;
		s_axis_tlast = lst;
		do @(negedge clk); while (!req_taken);
		s_axis_tvalid = 1'b0;
		n_items++;
		if (n_items > QUIET_AFTER) quiet = 1'b1;
	endtask

	// whole message, last flag on the final byte, stray queries in between
	task automatic send_msg(logic [1:0] req, logic [7:0] bytes [$]);
		foreach (bytes[i]) begin
			if ($urandom_range(0, 49) == 0)
				send_req(mpv_pkg::REQ_QUERY, 8'($urandom), 1'($urandom));
			send_req(req, bytes[i], i == bytes.size() - 1);
		end
	endtask

	task automatic send_leaf(int len);
		logic [7:0] bytes [$];
		repeat (len) bytes.push_back(8'($urandom));
		send_msg(mpv_pkg::REQ_LEAF, bytes);
	endtask

	// hash list of n chunks; the running hash sits at one of them unless spoiled
	// flaw: 0 none, 1 flipped bit in the hash chunk, 2 one byte short, 3 no hash
	task automatic send_level(int n, int flaw);
		logic [7:0] bytes [$];
		int at;
		at = $urandom_range(0, n - 1);
		for (int c = 0; c < n; c++)
			for (int i = 0; i < 32; i++)
				bytes.push_back((c == at && flaw != 3) ? hash_byte(i) : 8'($urandom));
		if (flaw == 1) bytes[at * 32 + $urandom_range(0, 31)] ^= 8'(1 << $urandom_range(0, 7));
		if (flaw == 2) void'(bytes.pop_back());
		send_msg(mpv_pkg::REQ_LEVEL, bytes);
	endtask

	task automatic proof_chain();
		int n;
		send_req(mpv_pkg::REQ_CLEAR, 8'($urandom), 1'($urandom));
		case ($urandom_range(0, 19))
			0: send_leaf(255);
			1: send_leaf(256);
			default: send_leaf($urandom_range(1, 40));
		endcase
		for (int l = 1; l <= mpv_pkg::PROOF_LEVELS; l++) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 4) : 1;
			send_level(n, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
			if ($urandom_range(0, 9) == 0) send_leaf($urandom_range(1, 8));
		end
		// list offered past the last level
		if ($urandom_range(0, 2) == 0) send_level(1, 0);
		send_req(mpv_pkg::REQ_QUERY, 8'($urandom), 1'($urandom));
	endtask

	initial begin
		clear_verifier();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = mpv_pkg::REQ_CLEAR;
		s_axis_tlast = 1'b0;
		n_items = 0; n_results = 0; n_errors = 0; n_proofs = 0;
		quiet = 1'b0;
		drv_typed = 1'b0;
		drv_want = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		foreach (dir_rows[i]) begin
			drv_typed = dir_rows[i].typed;
			drv_want = dir_rows[i].want;
			send_req(dir_rows[i].req, dir_rows[i].data, dir_rows[i].lst);
		end
		drv_typed = 1'b0;

		// count saturation on an overlong leaf
		send_leaf(512);

		// hold off until the verifier has answered everything
		while (verdict_q.size() != 0) @(negedge clk);

		// random part: mostly proofs, some noise and stray messages
		while (n_items < MIN_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1: repeat ($urandom_range(1, 20))
					send_req(2'($urandom), 8'($urandom), $urandom_range(0, 3) == 0);
				2: send_level($urandom_range(1, 3), $urandom_range(0, 3));
				3: send_leaf($urandom_range(1, 64));
				default: proof_chain();
			endcase
		end

		while (verdict_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("%0d requests, %0d results, %0d proofs carried to the top level",
			n_items, n_results, n_proofs);
		$display("%0d mismatches", n_errors);
		if (n_errors == 0 && verdict_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/mpv_pkg.sv
hw/rtl/merkle_proof_verifier.sv
dv/tb_merkle_proof_verifier.sv
